// ===== src/jpdd_pkg.sv =====
// Shared constants, types and command/status structs for the joystick
// frame to differential drive block. No dependencies.
package jpdd_pkg;

  // Gear steps across the full gear range
  localparam int GEAR_STEPS = 10;
  // Width of the gear value, which runs 0 .. GEAR_STEPS-1
  localparam int GEAR_W = $clog2(GEAR_STEPS);
  // Width of |m| * gear
  localparam int MG_W = 8 + GEAR_W;
  // Width of the per-lane work register
  localparam int PROD_W = 20;

  // Frame tags
  localparam logic [7:0] TAG_X = 8'h11;
  localparam logic [7:0] TAG_Y = 8'h21;
  localparam logic [7:0] TAG_G = 8'h31;

  // Saturation limit of received values
  localparam logic [9:0] VAL_MAX = 10'd1023;

  // Rotation by 45 degrees: (s * 707) / 1000
  localparam logic [9:0]  ROT_GAIN  = 10'd707;
  localparam int          SH_DIV1K  = 30;
  localparam logic [20:0] K_DIV1K   = 21'd1073742;  // ceil(2^30 / 1000)

  // Axis map: floor((r + 723) * 510 / 1446) == floor((r + 723) * 85 / 241)
  localparam logic [9:0]  AXIS_SPAN = 10'd723;
  localparam logic [6:0]  MAP_NUM   = 7'd85;
  localparam int          SH_DIV241 = 28;
  localparam logic [20:0] K_DIV241  = 21'd1113841;  // ceil(2^28 / 241)
  localparam logic [8:0]  DUTY_MID  = 9'd255;

  // Gear scaling: divide by GEAR_STEPS - 1
  localparam int          SH_GEAR   = 20;
  localparam logic [20:0] K_GEAR    =
    21'(((1 << SH_GEAR) + GEAR_STEPS - 2) / (GEAR_STEPS - 1));

  // Frame phase
  typedef enum logic [3:0] {
    PH_TAG_X, PH_X_LO, PH_X_HI,
    PH_TAG_Y, PH_Y_LO, PH_Y_HI,
    PH_TAG_G, PH_G_LO, PH_G_HI
  } phase_t;

  // Compute sequencer
  typedef enum logic [2:0] {
    SQ_IDLE, SQ_LOAD, SQ_DIV1K, SQ_MAP, SQ_DIV241, SQ_GEAR, SQ_STEP, SQ_STOP
  } seq_t;

  // Datapath lane operations
  typedef enum logic [2:0] {
    DP_HOLD, DP_LOAD, DP_DIV1K, DP_MAP, DP_DIV241, DP_GEAR
  } dp_op_t;

  // Controller to datapath
  typedef struct packed {
    logic   hold_low;
    logic   load_x;
    logic   load_y;
    logic   load_gear;
    dp_op_t op;
    logic   out_load;
    logic   out_stop;
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic tag_x_ok;
    logic tag_y_ok;
    logic tag_g_ok;
    logic out_free;
  } dp_stat_t;

endpackage

// ===== src/jpdd_ctrl.sv =====
// Controller: frame phase tracking and the compute sequencer.
// Depends on jpdd_pkg.
module jpdd_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  jpdd_pkg::dp_stat_t stat,
  output jpdd_pkg::dp_cmd_t  cmd
);

  jpdd_pkg::phase_t phase, phase_next;
  jpdd_pkg::seq_t   seq, seq_next;
  logic             accept;

  assign in_ready = (seq == jpdd_pkg::SQ_IDLE);
  assign accept   = in_valid && in_ready;

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= jpdd_pkg::PH_TAG_X;
      seq   <= jpdd_pkg::SQ_IDLE;
    end else begin
      phase <= phase_next;
      seq   <= seq_next;
    end
  end

  // Next state
  always_comb begin
    phase_next = phase;
    seq_next   = seq;
    unique case (seq)
      jpdd_pkg::SQ_IDLE: begin
        if (accept) begin
          unique case (phase)
            jpdd_pkg::PH_X_LO:  phase_next = jpdd_pkg::PH_X_HI;
            jpdd_pkg::PH_X_HI:  phase_next = jpdd_pkg::PH_TAG_Y;
            jpdd_pkg::PH_TAG_Y: begin
              if (stat.tag_y_ok) begin
                phase_next = jpdd_pkg::PH_Y_LO;
              end else begin
                phase_next = jpdd_pkg::PH_TAG_X;
                seq_next   = jpdd_pkg::SQ_STOP;
              end
            end
            jpdd_pkg::PH_Y_LO:  phase_next = jpdd_pkg::PH_Y_HI;
            jpdd_pkg::PH_Y_HI:  phase_next = jpdd_pkg::PH_TAG_G;
            jpdd_pkg::PH_TAG_G: begin
              if (stat.tag_g_ok) begin
                phase_next = jpdd_pkg::PH_G_LO;
              end else begin
                phase_next = jpdd_pkg::PH_TAG_X;
                seq_next   = jpdd_pkg::SQ_LOAD;
              end
            end
            jpdd_pkg::PH_G_LO:  phase_next = jpdd_pkg::PH_G_HI;
            jpdd_pkg::PH_G_HI: begin
              phase_next = jpdd_pkg::PH_TAG_X;
              seq_next   = jpdd_pkg::SQ_LOAD;
            end
            default: begin
              // expecting the x tag; unused codes land here too
              if (stat.tag_x_ok) begin
                phase_next = jpdd_pkg::PH_X_LO;
              end else begin
                phase_next = jpdd_pkg::PH_TAG_X;
                seq_next   = jpdd_pkg::SQ_STOP;
              end
            end
          endcase
        end
      end
      jpdd_pkg::SQ_LOAD:   seq_next = jpdd_pkg::SQ_DIV1K;
      jpdd_pkg::SQ_DIV1K:  seq_next = jpdd_pkg::SQ_MAP;
      jpdd_pkg::SQ_MAP:    seq_next = jpdd_pkg::SQ_DIV241;
      jpdd_pkg::SQ_DIV241: seq_next = jpdd_pkg::SQ_GEAR;
      jpdd_pkg::SQ_GEAR:   seq_next = jpdd_pkg::SQ_STEP;
      jpdd_pkg::SQ_STEP: begin
        if (stat.out_free) seq_next = jpdd_pkg::SQ_IDLE;
      end
      jpdd_pkg::SQ_STOP: begin
        if (stat.out_free) seq_next = jpdd_pkg::SQ_IDLE;
      end
      default: seq_next = jpdd_pkg::SQ_IDLE;
    endcase
  end

  // Datapath commands
  always_comb begin
    cmd = '0;
    cmd.op = jpdd_pkg::DP_HOLD;
    unique case (seq)
      jpdd_pkg::SQ_IDLE: begin
        if (accept) begin
          unique case (phase)
            jpdd_pkg::PH_X_LO, jpdd_pkg::PH_Y_LO, jpdd_pkg::PH_G_LO:
              cmd.hold_low = 1'b1;
            jpdd_pkg::PH_X_HI: cmd.load_x    = 1'b1;
            jpdd_pkg::PH_Y_HI: cmd.load_y    = 1'b1;
            jpdd_pkg::PH_G_HI: cmd.load_gear = 1'b1;
            default: ;
          endcase
        end
      end
      jpdd_pkg::SQ_LOAD:   cmd.op = jpdd_pkg::DP_LOAD;
      jpdd_pkg::SQ_DIV1K:  cmd.op = jpdd_pkg::DP_DIV1K;
      jpdd_pkg::SQ_MAP:    cmd.op = jpdd_pkg::DP_MAP;
      jpdd_pkg::SQ_DIV241: cmd.op = jpdd_pkg::DP_DIV241;
      jpdd_pkg::SQ_GEAR:   cmd.op = jpdd_pkg::DP_GEAR;
      jpdd_pkg::SQ_STEP:   cmd.out_load = stat.out_free;
      jpdd_pkg::SQ_STOP: begin
        cmd.out_load = stat.out_free;
        cmd.out_stop = 1'b1;
      end
      default: ;
    endcase
  end

endmodule

// ===== src/jpdd_dpath.sv =====
// Datapath: frame value registers, two drive lanes stepped by the
// controller, and the output register. Depends on jpdd_pkg.
module jpdd_dpath (
  input  logic              clk,
  input  logic              rst,
  input  logic [7:0]        rx_byte,
  input  jpdd_pkg::dp_cmd_t  cmd,
  output jpdd_pkg::dp_stat_t stat,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [23:0]       out_data,
  output logic              out_stopped
);

  localparam int GW = jpdd_pkg::GEAR_W;
  localparam int MW = jpdd_pkg::MG_W;
  localparam int PW = jpdd_pkg::PROD_W;

  logic [7:0]    low_hold;
  logic [9:0]    x_pos, y_pos, gear_pos;
  logic [9:0]    joined;

  logic [PW-1:0] prod      [2];
  logic          neg       [2];
  logic [PW-1:0] prod_next [2];
  logic          neg_next  [2];

  logic signed [11:0] sv      [2];
  logic [10:0]        smag    [2];
  logic [20:0]        p_rot   [2];
  logic [40:0]        t_div1k [2];
  logic [10:0]        v_map   [2];
  logic [16:0]        v85     [2];
  logic [37:0]        t_div241[2];
  logic [8:0]         q241    [2];
  logic [MW-1:0]      mg      [2];
  logic [MW+20:0]     t_gear  [2];
  logic [7:0]         duty    [2];
  logic               dir     [2];

  logic [14:0]   gscaled;
  logic [GW-1:0] gear;

  logic          out_valid_next;

  // Tag checks and output slot status
  assign stat.tag_x_ok = (rx_byte == jpdd_pkg::TAG_X);
  assign stat.tag_y_ok = (rx_byte == jpdd_pkg::TAG_Y);
  assign stat.tag_g_ok = (rx_byte == jpdd_pkg::TAG_G);
  assign stat.out_free = !out_valid || out_ready;

  // High byte joined with the held low byte, saturated to 1023
  assign joined = (|rx_byte[7:2]) ? jpdd_pkg::VAL_MAX : {rx_byte[1:0], low_hold};

  // Frame value registers
  always_ff @(posedge clk) begin
    if (rst) begin
      low_hold <= '0;
      x_pos    <= '0;
      y_pos    <= '0;
      gear_pos <= '0;
    end else begin
      if (cmd.hold_low)  low_hold <= rx_byte;
      if (cmd.load_x)    x_pos    <= joined;
      if (cmd.load_y)    y_pos    <= joined;
      if (cmd.load_gear) gear_pos <= joined;
    end
  end

  // Gear step: (GEAR_STEPS * (g + 1) - 1) >> 10
  assign gscaled = 15'(jpdd_pkg::GEAR_STEPS) * ({5'b0, gear_pos} + 15'd1) - 15'd1;
  assign gear    = GW'(gscaled >> 10);

  // Lane arithmetic; lane 0 drives motor a, lane 1 motor b
  always_comb begin
    // rotated sums: a = x - y, b = 1024 - x - y
    sv[0] = $signed({2'b0, x_pos}) - $signed({2'b0, y_pos});
    sv[1] = 12'sd1024 - $signed({2'b0, x_pos}) - $signed({2'b0, y_pos});
    for (int i = 0; i < 2; i++) begin
      smag[i]     = sv[i][11] ? 11'(-sv[i]) : sv[i][10:0];
      p_rot[i]    = 21'(smag[i]) * 21'(jpdd_pkg::ROT_GAIN);
      t_div1k[i]  = 41'(prod[i]) * 41'(jpdd_pkg::K_DIV1K);
      v_map[i]    = neg[i] ? {1'b0, jpdd_pkg::AXIS_SPAN} - {1'b0, prod[i][9:0]}
                           : {1'b0, jpdd_pkg::AXIS_SPAN} + {1'b0, prod[i][9:0]};
      v85[i]      = 17'(v_map[i]) * 17'(jpdd_pkg::MAP_NUM);
      t_div241[i] = 38'(prod[i][16:0]) * 38'(jpdd_pkg::K_DIV241);
      q241[i]     = t_div241[i][jpdd_pkg::SH_DIV241 +: 9];
      mg[i]       = MW'(prod[i][7:0]) * MW'(gear);
      t_gear[i]   = (MW + 21)'(prod[i][MW-1:0]) * (MW + 21)'(jpdd_pkg::K_GEAR);
      duty[i]     = t_gear[i][jpdd_pkg::SH_GEAR +: 8];
      dir[i]      = !neg[i] && (duty[i] != 8'd0);

      prod_next[i] = prod[i];
      neg_next[i]  = neg[i];
      unique case (cmd.op)
        jpdd_pkg::DP_LOAD: begin
          prod_next[i] = PW'(p_rot[i]);
          neg_next[i]  = sv[i][11];
        end
        jpdd_pkg::DP_DIV1K: begin
          prod_next[i] = PW'(t_div1k[i][jpdd_pkg::SH_DIV1K +: 10]);
        end
        jpdd_pkg::DP_MAP: begin
          prod_next[i] = PW'(v85[i]);
          neg_next[i]  = 1'b0;
        end
        jpdd_pkg::DP_DIV241: begin
          // m = q - 255, kept as sign and magnitude
          neg_next[i]  = (q241[i] < jpdd_pkg::DUTY_MID);
          prod_next[i] = (q241[i] < jpdd_pkg::DUTY_MID)
                         ? PW'(jpdd_pkg::DUTY_MID - q241[i])
                         : PW'(q241[i] - jpdd_pkg::DUTY_MID);
        end
        jpdd_pkg::DP_GEAR: begin
          prod_next[i] = PW'(mg[i]);
        end
        default: ;
      endcase
    end
  end

  // Lane registers
  always_ff @(posedge clk) begin
    for (int i = 0; i < 2; i++) begin
      prod[i] <= prod_next[i];
      neg[i]  <= neg_next[i];
    end
  end

  // Output register
  always_comb begin
    out_valid_next = out_valid;
    if (cmd.out_load) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      if (cmd.out_stop) begin
        out_data    <= '0;
        out_stopped <= 1'b1;
      end else begin
        out_data    <= {6'b0, dir[1], duty[1], dir[0], duty[0]};
        out_stopped <= 1'b0;
      end
    end
  end

endmodule

// ===== src/joystick_packet_to_diff_drive.sv =====
// Top level of the joystick frame to differential drive block.
// Depends on jpdd_pkg, jpdd_ctrl and jpdd_dpath.
//
// Input stream (s_*): one received serial byte per transaction. A frame is
// tag 0x11, x low, x high, tag 0x21, y low, y high, tag 0x31, gear low,
// gear high. Output stream (m_*): one drive command per finished frame, or
// a stop command (m_tuser high, all duties and directions zero) after a bad
// x or y tag. A bad gear tag ends the frame and keeps the old gear.
// Sequencing: a byte that gives no result is taken back to back with the
// next. A byte that ends a frame holds s_tready low until the sequencer has
// passed five steps through the two-lane multiply/reciprocal datapath and
// the load of the output register. A stop goes straight to the load of the
// output register.
// Stall: the output register holds its result while m_tready is low; bytes
// keep being taken meanwhile until the next result is ready to load, at
// which point s_tready stays low until the output register frees up.
// Reset (rst, synchronous): frame phase back to the x tag, stored x, y,
// gear and low byte cleared, output empty.
module joystick_packet_to_diff_drive (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] rx_byte
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // [7:0] duty_a, [8] dir_a, [16:9] duty_b, [17] dir_b
  output logic        m_tuser    // [0] stopped
);

  jpdd_pkg::dp_cmd_t  cmd;
  jpdd_pkg::dp_stat_t stat;

  // Frame phase and compute sequencing
  jpdd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Value registers, drive lanes and output register
  jpdd_dpath u_dpath (
    .clk         (clk),
    .rst         (rst),
    .rx_byte     (s_tdata),
    .cmd         (cmd),
    .stat        (stat),
    .out_valid   (m_tvalid),
    .out_ready   (m_tready),
    .out_data    (m_tdata),
    .out_stopped (m_tuser)
  );

endmodule

// ===== dv/tb.sv =====
// Self-checking testbench for joystick_packet_to_diff_drive.
// Sends serial command frames (clean, broken and noise) over the byte stream and
// predicts every drive or stop command. Depends on jpdd_pkg and the RTL in src.
module tb;
  import jpdd_pkg::*;

  localparam int LIMIT_CYCLES = 300000;
  localparam int RANDOM_ITEMS = 1200;
  localparam int STEADY_ITEMS = 300;

  // One drive command as it leaves the block
  typedef struct packed {
    logic       stopped;
    logic       dir_b;
    logic [7:0] duty_b;
    logic       dir_a;
    logic [7:0] duty_a;
  } drive_cmd_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'h00;  // [7:0] rx_byte
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;          // [7:0] duty_a, [8] dir_a, [16:9] duty_b, [17] dir_b
  logic        m_tuser;          // [0] stopped

  // Predicted receiver state
  phase_t     rx_phase = PH_TAG_X;
  logic [7:0] rx_low = 8'h00;
  logic [9:0] stick_x = 10'd0;
  logic [9:0] stick_y = 10'd0;
  logic [9:0] gear_pos = 10'd0;

  drive_cmd_t pending_cmds[$];
  int         mismatches = 0;
  int         sent_items = 0;
  int         gap_pct = 0;
  int         stall_pct = 0;

  joystick_packet_to_diff_drive dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Run watchdog
  initial begin
    repeat (LIMIT_CYCLES) @(posedge clk);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Combine high and low byte, saturating at the 10-bit maximum
  function automatic logic [9:0] join_sat(input logic [7:0] hi, input logic [7:0] lo);
    logic [15:0] v;
    v = {hi, lo};
    return (v > 16'd1023) ? VAL_MAX : v[9:0];
  endfunction

  // One axis: map +-723 to +-255, then scale by gear / (steps - 1)
  function automatic int axis_drive(input int rot, input int gear);
    int m;
    m = (rot + 723) * 510 / 1446 - 255;
    return m * gear / (GEAR_STEPS - 1);
  endfunction

  // Drive command from the stored x, y and gear
  function automatic drive_cmd_t mix_drive();
    drive_cmd_t cmd;
    int xc, yc, ra, rb, gear, da, db;
    xc = int'(stick_x) - 512;
    yc = 512 - int'(stick_y);
    ra = ((xc + yc) * 707) / 1000;
    rb = ((yc - xc) * 707) / 1000;
    gear = (GEAR_STEPS * (int'(gear_pos) + 1) - 1) / 1024;
    da = axis_drive(ra, gear);
    db = axis_drive(rb, gear);
    if (da < 0) da = -da;
    if (db < 0) db = -db;
    cmd.duty_a = (da > 255) ? 8'd255 : 8'(da);
    cmd.duty_b = (db > 255) ? 8'd255 : 8'(db);
    cmd.dir_a = (axis_drive(ra, gear) > 0);
    cmd.dir_b = (axis_drive(rb, gear) > 0);
    cmd.stopped = 1'b0;
    return cmd;
  endfunction

  // Advance the predicted frame state by one byte; returns 1 when a command is due
  function automatic bit frame_step(input logic [7:0] b, output drive_cmd_t cmd);
    cmd = '0;
    case (rx_phase)
      PH_X_LO, PH_Y_LO, PH_G_LO: begin
        rx_low = b;
        rx_phase = phase_t'(rx_phase + 1);
        return 1'b0;
      end
      PH_X_HI: begin
        stick_x = join_sat(b, rx_low);
        rx_phase = PH_TAG_Y;
        return 1'b0;
      end
      PH_Y_HI: begin
        stick_y = join_sat(b, rx_low);
        rx_phase = PH_TAG_G;
        return 1'b0;
      end
      PH_TAG_Y: begin
        if (b == TAG_Y) begin
          rx_phase = PH_Y_LO;
          return 1'b0;
        end
        rx_phase = PH_TAG_X;
        cmd.stopped = 1'b1;
        return 1'b1;
      end
      PH_TAG_G: begin
        // A bad gear tag ends the frame with the old gear
        rx_phase = (b == TAG_G) ? PH_G_LO : PH_TAG_X;
        if (b == TAG_G) return 1'b0;
        cmd = mix_drive();
        return 1'b1;
      end
      PH_G_HI: begin
        gear_pos = join_sat(b, rx_low);
        rx_phase = PH_TAG_X;
        cmd = mix_drive();
        return 1'b1;
      end
      default: begin
        if (b == TAG_X) begin
          rx_phase = PH_X_LO;
          return 1'b0;
        end
        rx_phase = PH_TAG_X;
        cmd.stopped = 1'b1;
        return 1'b1;
      end
    endcase
  endfunction

  // Predict on every byte transaction, check every command transaction
  always @(posedge clk) begin
    drive_cmd_t want, got;
    if (!rst) begin
      if (s_tvalid && s_tready === 1'b1) begin
        if (frame_step(s_tdata, want)) pending_cmds.push_back(want);
      end
      if (m_tvalid === 1'b1 && m_tready) begin
        got.duty_a = m_tdata[7:0];
        got.dir_a = m_tdata[8];
        got.duty_b = m_tdata[16:9];
        got.dir_b = m_tdata[17];
        got.stopped = m_tuser;
        if (pending_cmds.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected command: duty_a %0d dir_a %b duty_b %0d dir_b %b stopped %b",
                     got.duty_a, got.dir_a, got.duty_b, got.dir_b, got.stopped);
        end else begin
          want = pending_cmds.pop_front();
          if (got.duty_a !== want.duty_a || got.dir_a !== want.dir_a ||
              got.duty_b !== want.duty_b || got.dir_b !== want.dir_b ||
              got.stopped !== want.stopped) begin
            mismatches++;
            if (mismatches <= 10)
              $display("cmd mismatch: exp a %0d/%b b %0d/%b stop %b, got a %0d/%b b %0d/%b stop %b",
                       want.duty_a, want.dir_a, want.duty_b, want.dir_b, want.stopped,
                       got.duty_a, got.dir_a, got.duty_b, got.dir_b, got.stopped);
          end
        end
      end
    end
  end

  // Receiver backpressure in random bursts
  initial begin
    forever begin
      @(posedge clk);
      if (!rst && $urandom_range(0, 99) < stall_pct) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
      m_tready <= 1'b1;
    end
  end

  // Send one byte, with an optional idle burst in front of it
  task automatic send_byte(input logic [7:0] b);
    if ($urandom_range(0, 99) < gap_pct) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= b;
    do @(posedge clk); while (s_tready !== 1'b1);
    sent_items++;
  endtask

  // Send the first n_bytes of a frame built from the given tags and values
  task automatic send_frame(input logic [7:0] tx, input logic [15:0] xv,
                            input logic [7:0] ty, input logic [15:0] yv,
                            input logic [7:0] tg, input logic [15:0] gv,
                            input int n_bytes);
    logic [7:0] bytes[9];
    bytes = '{tx, xv[7:0], xv[15:8], ty, yv[7:0], yv[15:8], tg, gv[7:0], gv[15:8]};
    for (int i = 0; i < n_bytes; i++) send_byte(bytes[i]);
  endtask

  // Value for a frame field: mostly in range, with the extremes and saturating values
  function automatic logic [15:0] pick_value();
    case ($urandom_range(0, 9))
      0: return 16'd0;
      1: return 16'd1023;
      2: return 16'd512;
      3: return 16'($urandom());
      default: return 16'($urandom_range(0, 1023));
    endcase
  endfunction

  // Bad tags in each position and saturating values
  task automatic test_directed();
    gap_pct = 0;
    stall_pct = 0;
    send_byte(8'hFF);                                                    // bad x tag
    send_frame(TAG_X, 16'h0000, TAG_Y, 16'h03FF, 8'h00, 16'h0, 7);      // bad gear tag, gear 0
    send_frame(TAG_X, 16'h0100, 8'h00, 16'h0, 8'h0, 16'h0, 4);          // bad y tag
    send_frame(TAG_X, 16'hFFFF, TAG_Y, 16'h0000, TAG_G, 16'hFFFF, 9);   // saturation, top gear
  endtask

  // Mostly clean frames with random content, plus broken frames and noise
  task automatic run_frames(input int n_items, input bit allow_idle);
    logic [7:0] tags[3];
    int stop_at;
    stop_at = sent_items + n_items;
    while (sent_items < stop_at) begin
      if (allow_idle && $urandom_range(0, 15) == 0) begin
        case ($urandom_range(0, 2))
          0: gap_pct = 0;
          1: gap_pct = 15;
          default: gap_pct = 50;
        endcase
        case ($urandom_range(0, 2))
          0: stall_pct = 0;
          1: stall_pct = 15;
          default: stall_pct = 50;
        endcase
      end
      tags = '{TAG_X, TAG_Y, TAG_G};
      case ($urandom_range(0, 19))
        0, 1: tags[$urandom_range(0, 2)] = 8'($urandom());
        2: begin
          repeat ($urandom_range(1, 5)) send_byte(8'($urandom()));
          continue;
        end
        default: ;
      endcase
      send_frame(tags[0], pick_value(), tags[1], pick_value(), tags[2], pick_value(),
                 (tags[0] == TAG_X && $urandom_range(0, 19) == 0) ? $urandom_range(1, 8) : 9);
    end
  endtask

  task automatic test_random_idle();
    run_frames(RANDOM_ITEMS, 1'b1);
  endtask

  // Closing stretch at full rate on both sides
  task automatic test_full_rate();
    gap_pct = 0;
    stall_pct = 0;
    run_frames(STEADY_ITEMS, 1'b0);
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_random_idle();
    test_full_rate();
    s_tvalid <= 1'b0;
    while (pending_cmds.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatches == 0 && pending_cmds.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
src/jpdd_pkg.sv
src/jpdd_ctrl.sv
src/jpdd_dpath.sv
src/joystick_packet_to_diff_drive.sv
dv/tb.sv
